@@ rtl/clnw_pkg.sv @@
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types and constants of the character LCD nibble writer: item kinds,
// classified operations, sequencer phases, register indexes and reset values.
// ----------------------------------------------------------------------------
package clnw_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned TICK_W    = 16;

	// Raw item kinds on the input port
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SETUP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_HOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_HOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP  = 3'd4;

	// Register reset values
	localparam logic [TICK_W-1:0] SETUP_RST     = 16'd6;
	localparam logic [TICK_W-1:0] PULSE_RST     = 16'd6;
	localparam logic [TICK_W-1:0] DATA_HOLD_RST = 16'd1600;
	localparam logic [TICK_W-1:0] CMD_HOLD_RST  = 16'd40;
	localparam logic [TICK_W-1:0] BYTE_GAP_RST  = 16'd1000;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_CMD,
		OP_CHAR,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETUP,
		PH_PULSE,
		PH_HOLD,
		PH_GAP
	} phase_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} op_item_t;

	typedef struct packed {
		logic       reg_select;
		logic       enable_pin;
		logic [3:0] bus_nibble;
		logic       busy_res;
		logic       rejected;
	} result_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [TICK_W-1:0]    data;
	} cfg_wr_t;

endpackage

@@ rtl/char_lcd_nibble_writer_top.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Character LCD 4-bit write interface: queued items in, pin states out.
// ----------------------------------------------------------------------------
// Takes one item per clock (a tick, a command byte or a character byte) and
// returns one result per item with the RS, E and DB7..DB4 levels, a busy flag
// and a flag for a send that arrived while busy and was dropped. An item is
// classified and queued on the input side; the pin sequencer takes one queued
// operation per cycle and writes its result to the output queue, so the
// sustained rate is one item per clock when neither queue stalls; an item
// passes the input queue and then the output queue on its way to the output
// ports. Timing registers are written through the cfg port (always ready); a
// new value applies the next time that count is loaded. All times are counted
// in tick items, not clocks.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_top #(
	parameter int unsigned OP_DEPTH  = 2,
	parameter int unsigned RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [7:0]  payload,
	output logic        empty,
	input  logic        pop,
	output logic        reg_select,
	output logic        enable_pin,
	output logic [3:0]  bus_nibble,
	output logic        busy_res,
	output logic        rejected,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import clnw_pkg::*;

	localparam int unsigned RES_W = $bits(result_t);

	op_item_t          op_item;
	logic              op_valid;
	logic              op_pop;
	logic              res_push;
	logic              res_full;
	result_t           res_item;
	result_t           res_head;
	logic [RES_W-1:0]  res_vec;
	cfg_wr_t           cfg_wr;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	clnw_front #(
		.DEPTH (OP_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.payload  (payload),
		.op_valid (op_valid),
		.op_item  (op_item),
		.op_pop   (op_pop)
	);

	clnw_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.op_valid (op_valid),
		.op_item  (op_item),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_item (res_item)
	);

	clnw_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_item),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_vec),
		.empty   (empty)
	);

	assign res_head   = result_t'(res_vec);
	assign reg_select = res_head.reg_select;
	assign enable_pin = res_head.enable_pin;
	assign bus_nibble = res_head.bus_nibble;
	assign busy_res   = res_head.busy_res;
	assign rejected   = res_head.rejected;

endmodule

@@ rtl/clnw_fifo.sv @@
// ----------------------------------------------------------------------------
// clnw_fifo
// Small first-in first-out queue in flip-flops with push/full and pop/empty.
// ----------------------------------------------------------------------------
module clnw_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic             rd_en;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_en   = push && !full;
	assign rd_en   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/clnw_front.sv @@
// ----------------------------------------------------------------------------
// clnw_front
// Input side: classify each incoming item into an operation and queue it for
// the pin sequencer.
// ----------------------------------------------------------------------------
module clnw_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          kind,
	input  logic [7:0]          payload,
	output logic                op_valid,
	output clnw_pkg::op_item_t  op_item,
	input  logic                op_pop
);
	import clnw_pkg::*;

	localparam int unsigned ITEM_W = $bits(op_item_t);

	op_item_t          dec_item;
	logic [ITEM_W-1:0] rd_vec;
	logic              q_empty;

	always_comb begin
		dec_item.data = payload;
		unique case (kind)
			KIND_TICK: dec_item.op = OP_TICK;
			KIND_CMD:  dec_item.op = OP_CMD;
			KIND_CHAR: dec_item.op = OP_CHAR;
			default:   dec_item.op = OP_NOP;
		endcase
	end

	clnw_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (DEPTH)
	) u_op_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (dec_item),
		.full    (full),
		.pop     (op_pop),
		.rd_data (rd_vec),
		.empty   (q_empty)
	);

	assign op_valid = !q_empty;
	assign op_item  = op_item_t'(rd_vec);

endmodule

@@ rtl/clnw_seq.sv @@
// ----------------------------------------------------------------------------
// clnw_seq
// Pin sequencer: holds the timing registers and walks each byte through
// setup, pulse and hold per nibble and then the byte gap, one operation per
// cycle while an operation is queued and the result queue is not full.
// ----------------------------------------------------------------------------
module clnw_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  clnw_pkg::cfg_wr_t   cfg_wr,
	input  logic                op_valid,
	input  clnw_pkg::op_item_t  op_item,
	output logic                op_pop,
	input  logic                res_full,
	output logic                res_push,
	output clnw_pkg::result_t   res_item
);
	import clnw_pkg::*;

	logic [TICK_W-1:0] setup_q;
	logic [TICK_W-1:0] pulse_q;
	logic [TICK_W-1:0] data_hold_q;
	logic [TICK_W-1:0] cmd_hold_q;
	logic [TICK_W-1:0] byte_gap_q;

	phase_t            phase_q, phase_d;
	logic              low_half_q, low_half_d;
	logic [7:0]        held_q, held_d;
	logic              rs_q, rs_d;
	logic              e_q, e_d;
	logic [TICK_W-1:0] wait_q, wait_d;
	logic              rej;
	logic              go;

	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

	assign go       = op_valid && !res_full;
	assign op_pop   = go;
	assign res_push = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q     <= SETUP_RST;
			pulse_q     <= PULSE_RST;
			data_hold_q <= DATA_HOLD_RST;
			cmd_hold_q  <= CMD_HOLD_RST;
			byte_gap_q  <= BYTE_GAP_RST;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				REG_SETUP:     setup_q     <= cfg_wr.data;
				REG_PULSE:     pulse_q     <= cfg_wr.data;
				REG_DATA_HOLD: data_hold_q <= cfg_wr.data;
				REG_CMD_HOLD:  cmd_hold_q  <= cfg_wr.data;
				REG_BYTE_GAP:  byte_gap_q  <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			low_half_q <= 1'b0;
			held_q     <= '0;
			rs_q       <= 1'b0;
			e_q        <= 1'b0;
			wait_q     <= '0;
		end else if (go) begin
			phase_q    <= phase_d;
			low_half_q <= low_half_d;
			held_q     <= held_d;
			rs_q       <= rs_d;
			e_q        <= e_d;
			wait_q     <= wait_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		low_half_d = low_half_q;
		held_d     = held_q;
		rs_d       = rs_q;
		e_d        = e_q;
		wait_d     = wait_q;
		rej        = 1'b0;

		unique case (op_item.op)
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (wait_q > TICK_W'(1)) begin
						wait_d = wait_q - 1'b1;
					end else begin
						unique case (phase_q)
							PH_SETUP: begin
								phase_d = PH_PULSE;
								e_d     = 1'b1;
								wait_d  = at_least_one(pulse_q);
							end
							PH_PULSE: begin
								phase_d = PH_HOLD;
								e_d     = 1'b0;
								wait_d  = at_least_one(rs_q ? data_hold_q : cmd_hold_q);
							end
							PH_HOLD: begin
								e_d = 1'b0;
								if (!low_half_q) begin
									// second nibble goes through setup again
									low_half_d = 1'b1;
									phase_d    = PH_SETUP;
									wait_d     = at_least_one(setup_q);
								end else begin
									phase_d = PH_GAP;
									wait_d  = at_least_one(byte_gap_q);
								end
							end
							default: begin
								phase_d = PH_IDLE;
								e_d     = 1'b0;
								wait_d  = '0;
							end
						endcase
					end
				end
			end
			OP_CMD, OP_CHAR: begin
				if (phase_q != PH_IDLE) begin
					// drop the send, flag it
					rej = 1'b1;
				end else begin
					held_d     = op_item.data;
					rs_d       = (op_item.op == OP_CHAR);
					low_half_d = 1'b0;
					phase_d    = PH_SETUP;
					e_d        = 1'b0;
					wait_d     = at_least_one(setup_q);
				end
			end
			default: ;
		endcase

		res_item.reg_select = rs_d;
		res_item.enable_pin = e_d;
		res_item.bus_nibble = low_half_d ? held_d[3:0] : held_d[7:4];
		res_item.busy_res   = (phase_d != PH_IDLE);
		res_item.rejected   = rej;
	end

endmodule

@@ verif/char_lcd_nibble_writer_top_tb.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top_tb
// Self-checking bench for the character LCD 4-bit write interface.
// ----------------------------------------------------------------------------
// Items are pushed by a clocked driver from a pending list that the stimulus
// process fills phase by phase. Each accepted item runs through a local pin
// sequencer model and the predicted pin levels are queued. A clocked monitor
// pops results at random and compares every field with the oldest prediction.
// Timing registers are rewritten between phases, once all results are back:
// reset values, all zero, a long byte gap, and random small settings.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_top_tb;

	import clnw_pkg::*;

	localparam logic [1:0] KIND_NOP   = 2'd3;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0] op_kind;
		logic [7:0] byte_val;
	} lcd_item_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        push       = 1'b0;
	logic        full;
	logic [1:0]  kind       = KIND_TICK;
	logic [7:0]  payload    = '0;
	logic        empty;
	logic        pop        = 1'b0;
	logic        reg_select;
	logic        enable_pin;
	logic [3:0]  bus_nibble;
	logic        busy_res;
	logic        rejected;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index  = '0;
	logic [15:0] cfg_data   = '0;

	// Local copy of the timing registers
	logic [15:0] t_setup     = SETUP_RST;
	logic [15:0] t_pulse     = PULSE_RST;
	logic [15:0] t_data_hold = DATA_HOLD_RST;
	logic [15:0] t_cmd_hold  = CMD_HOLD_RST;
	logic [15:0] t_gap       = BYTE_GAP_RST;

	// Local copy of the pin sequencer
	phase_t      seq_phase    = PH_IDLE;
	logic        second_half  = 1'b0;
	logic [7:0]  latched_byte = '0;
	logic        rs_pin       = 1'b0;
	logic        e_pin        = 1'b0;
	logic [15:0] ticks_left   = '0;

	lcd_item_t   items_to_send[$];
	result_t     pin_states_due[$];
	lcd_item_t   next_item;
	result_t     want;
	logic        idling_on    = 1'b1;
	int unsigned send_gap     = 0;
	int unsigned pop_gap      = 0;
	int unsigned items_queued = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches   = 0;

	char_lcd_nibble_writer_top i_dut (.*);

	always #10 clk = ~clk;

	function automatic logic [15:0] min_one(input logic [15:0] v);
		return (v == '0) ? 16'd1 : v;
	endfunction

	function automatic void load_phase(input phase_t nxt);
		seq_phase = nxt;
		case (nxt)
			PH_SETUP: begin
				e_pin = 1'b0;
				ticks_left = min_one(t_setup);
			end
			PH_PULSE: begin
				e_pin = 1'b1;
				ticks_left = min_one(t_pulse);
			end
			PH_HOLD: begin
				e_pin = 1'b0;
				ticks_left = min_one(rs_pin ? t_data_hold : t_cmd_hold);
			end
			PH_GAP: begin
				e_pin = 1'b0;
				ticks_left = min_one(t_gap);
			end
			default: begin
				seq_phase = PH_IDLE;
				e_pin = 1'b0;
				ticks_left = '0;
			end
		endcase
	endfunction

	function automatic void count_tick();
		if (seq_phase != PH_IDLE) begin
			if (ticks_left > 16'd1) begin
				ticks_left--;
			end else begin
				case (seq_phase)
					PH_SETUP: load_phase(PH_PULSE);
					PH_PULSE: load_phase(PH_HOLD);
					PH_HOLD: begin
						if (!second_half) begin
							second_half = 1'b1;
							load_phase(PH_SETUP);
						end else begin
							load_phase(PH_GAP);
						end
					end
					default: load_phase(PH_IDLE);
				endcase
			end
		end
	endfunction

	function automatic result_t next_pins(input logic [1:0] k, input logic [7:0] d);
		result_t r;
		r = '0;
		case (k)
			KIND_TICK: count_tick();
			KIND_CMD, KIND_CHAR: begin
				if (seq_phase != PH_IDLE) begin
					r.rejected = 1'b1;
				end else begin
					latched_byte = d;
					rs_pin = (k == KIND_CHAR);
					second_half = 1'b0;
					load_phase(PH_SETUP);
				end
			end
			default: ;
		endcase
		r.reg_select = rs_pin;
		r.enable_pin = e_pin;
		r.bus_nibble = second_half ? latched_byte[3:0] : latched_byte[7:4];
		r.busy_res   = (seq_phase != PH_IDLE);
		return r;
	endfunction

	// Ticks from an accepted send until the sequencer is idle again
	function automatic int byte_ticks(input logic is_char);
		int span;
		span = 2 * (min_one(t_setup) + min_one(t_pulse)
			+ min_one(is_char ? t_data_hold : t_cmd_hold)) + min_one(t_gap);
		return span;
	endfunction

	function automatic void check_pin(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// Driver: hold the item while full, otherwise advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			kind <= KIND_TICK;
			payload <= '0;
			send_gap <= 0;
		end else begin
			if (push && !full) begin
				pin_states_due.push_back(next_pins(kind, payload));
			end
			if (!push || !full) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					push <= 1'b0;
				end else if (items_to_send.size() == 0) begin
					push <= 1'b0;
				end else if (idling_on && $urandom_range(0, 11) == 0) begin
					send_gap <= $urandom_range(0, 15);
					push <= 1'b0;
				end else begin
					next_item = items_to_send.pop_front();
					push <= 1'b1;
					kind <= next_item.op_kind;
					payload <= next_item.byte_val;
				end
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap <= 0;
		end else begin
			if (pop && !empty) begin
				if (pin_states_due.size() == 0) begin
					$error("result transfer with no prediction pending");
					mismatches++;
				end else begin
					want = pin_states_due.pop_front();
					check_pin("reg_select", want.reg_select, reg_select);
					check_pin("enable_pin", want.enable_pin, enable_pin);
					check_pin("bus_nibble", want.bus_nibble, bus_nibble);
					check_pin("busy_res", want.busy_res, busy_res);
					check_pin("rejected", want.rejected, rejected);
					results_checked++;
				end
			end
			if (pop_gap != 0) begin
				pop_gap <= pop_gap - 1;
				pop <= 1'b0;
			end else if (idling_on && $urandom_range(0, 11) == 0) begin
				pop_gap <= $urandom_range(0, 15);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic queue_item(input logic [1:0] k, input logic [7:0] d);
		items_to_send.push_back('{op_kind: k, byte_val: d});
		items_queued++;
	endtask

	task automatic queue_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			queue_item(KIND_TICK, 8'($urandom));
		end
	endtask

	task automatic wait_all_results();
		while (results_checked != items_queued) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timing(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SETUP:     t_setup = val;
			REG_PULSE:     t_pulse = val;
			REG_DATA_HOLD: t_data_hold = val;
			REG_CMD_HOLD:  t_cmd_hold = val;
			REG_BYTE_GAP:  t_gap = val;
			default: ;
		endcase
	endtask

	function automatic logic [15:0] pick_ticks();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'($urandom_range(10, 40));
			default: return 16'($urandom_range(2, 9));
		endcase
	endfunction

	task automatic randomize_timing();
		write_timing(REG_SETUP, pick_ticks());
		write_timing(REG_PULSE, pick_ticks());
		write_timing(REG_DATA_HOLD, pick_ticks());
		write_timing(REG_CMD_HOLD, pick_ticks());
		write_timing(REG_BYTE_GAP, pick_ticks());
	endtask

	function automatic logic [1:0] stray_send_kind();
		case ($urandom_range(0, 2))
			0: return KIND_CMD;
			1: return KIND_CHAR;
			default: return KIND_NOP;
		endcase
	endfunction

	// Mostly complete byte transfers with random content, some stray items
	task automatic queue_traffic(input int budget);
		int made;
		int span;
		logic [1:0] k;
		made = 0;
		while (made < budget) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_item(2'($urandom_range(0, 3)), 8'($urandom));
				made++;
			end else begin
				k = $urandom_range(0, 1) ? KIND_CHAR : KIND_CMD;
				span = byte_ticks(k == KIND_CHAR);
				queue_item(k, 8'($urandom));
				made++;
				for (int i = 0; i < span; i++) begin
					if ($urandom_range(0, 11) == 0) begin
						queue_item(stray_send_kind(), 8'($urandom));
						made++;
					end
					queue_item(KIND_TICK, 8'($urandom));
					made++;
				end
				queue_ticks($urandom_range(0, 2));
			end
		end
	endtask

	initial begin
		#200_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset timing: nop, idle tick, command, sends while busy, first nibble
		queue_item(KIND_NOP, 8'hFF);
		queue_item(KIND_TICK, 8'h3C);
		queue_item(KIND_CMD, 8'hFF);
		queue_item(KIND_CHAR, 8'h00);
		queue_item(KIND_CMD, 8'h12);
		queue_item(KIND_NOP, 8'h00);
		queue_ticks(30);
		queue_item(KIND_CHAR, 8'h77);
		queue_ticks(30);
		wait_all_results();

		// Zero counts load as a single tick; the open transfer finishes under
		// them; unused index is ignored
		write_timing(REG_SETUP, 16'd0);
		write_timing(REG_PULSE, 16'd0);
		write_timing(REG_DATA_HOLD, 16'd0);
		write_timing(REG_CMD_HOLD, 16'd0);
		write_timing(REG_BYTE_GAP, 16'd0);
		write_timing(REG_UNUSED, 16'hFFFF);
		queue_ticks(8);
		queue_item(KIND_CHAR, 8'hA5);
		queue_ticks(3);
		queue_item(KIND_CMD, 8'h5A);
		queue_ticks(byte_ticks(1'b1) - 3);
		queue_item(KIND_CMD, 8'h5A);
		queue_ticks(2);
		queue_item(KIND_NOP, 8'hC3);
		queue_ticks(byte_ticks(1'b0));
		wait_all_results();

		// Long byte gap after one command
		write_timing(REG_SETUP, 16'd1);
		write_timing(REG_PULSE, 16'd1);
		write_timing(REG_CMD_HOLD, 16'd1);
		write_timing(REG_DATA_HOLD, 16'hFFFF);
		write_timing(REG_BYTE_GAP, 16'd200);
		queue_item(KIND_CMD, 8'h81);
		queue_ticks(byte_ticks(1'b0) - 1);
		queue_item(KIND_CHAR, 8'h7E);
		queue_ticks(2);
		wait_all_results();

		for (int p = 0; p < 5; p++) begin
			randomize_timing();
			queue_traffic(110);
			wait_all_results();
		end

		@(posedge clk);
		idling_on <= 1'b0;
		randomize_timing();
		queue_traffic(80);
		wait_all_results();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && pin_states_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
